// ----- sv/dlp_pkg.sv -----
// Shared types, constants and helper functions of the display list packer.
`timescale 1ns / 1ps
`default_nettype none

package dlp_pkg;

   localparam int COMMANDS_PER_GROUP = 4;
   localparam int COUNT_WIDTH        = 32;
   localparam int MAX_PARAMS         = 2 * COMMANDS_PER_GROUP;
   localparam int CMD_CNT_W          = $clog2(COMMANDS_PER_GROUP + 1);
   localparam int CMD_IDX_W          = $clog2(COMMANDS_PER_GROUP);
   localparam int PAR_CNT_W          = $clog2(MAX_PARAMS + 1);
   localparam int PAR_IDX_W          = $clog2(MAX_PARAMS);
   // The queue depth must stay a power of two: the pointers wrap naturally.
   localparam int QUEUE_DEPTH        = 4;
   localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);
   localparam int ERR_WIDTH          = 74;

   typedef logic signed [ERR_WIDTH-1:0] err_type;

   typedef enum logic [2:0] {
      OP_NOP      = 3'd0,
      OP_RESTORE  = 3'd1,
      OP_BEGIN    = 3'd2,
      OP_END      = 3'd3,
      OP_NORMAL   = 3'd4,
      OP_TEXCOORD = 3'd5,
      OP_VERTEX   = 3'd6,
      OP_FINISH   = 3'd7
   } opcode_type;

   localparam logic [7:0] CMD_NOP      = 8'h00;
   localparam logic [7:0] CMD_RESTORE  = 8'h14;
   localparam logic [7:0] CMD_BEGIN    = 8'h40;
   localparam logic [7:0] CMD_END      = 8'h41;
   localparam logic [7:0] CMD_NORMAL   = 8'h21;
   localparam logic [7:0] CMD_TEXCOORD = 8'h22;
   localparam logic [7:0] CMD_VTX16    = 8'h23;
   localparam logic [7:0] CMD_VTX10    = 8'h24;
   localparam logic [7:0] CMD_VTX_XY   = 8'h25;
   localparam logic [7:0] CMD_VTX_XZ   = 8'h26;
   localparam logic [7:0] CMD_VTX_YZ   = 8'h27;

   localparam logic [9:0] NRM_MAX = 10'h1FF;
   localparam logic [9:0] NRM_MIN = 10'h200;

   localparam int FLAG_VTX = 0;
   localparam int FLAG_NRM = 1;
   localparam int FLAG_TEX = 2;

   // One command as the front hands it to the back.
   typedef struct packed {
      logic        is_finish;
      logic [7:0]  cmd;
      logic [1:0]  nparams;
      logic [31:0] p0;
      logic [31:0] p1;
   } entry_type;

   typedef enum logic [1:0] {
      BK_RUN   = 2'd0,
      BK_FLUSH = 2'd1,
      BK_COUNT = 2'd2
   } back_state_type;

   // Arithmetic shift right by k that rounds toward zero.
   function automatic logic signed [31:0] trunc_shift(input logic signed [31:0] x,
                                                      input int k);
      logic signed [31:0] bias;
      bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      return (x + bias) >>> k;
   endfunction

endpackage

`default_nettype wire

// ----- sv/gpu_display_list_packer.sv -----
// Top level of the display list packer: front, command queue and back.
//
// The request channel takes one geometry command per word: tuser carries the
// opcode, tdata the argument and the three fixed-point coordinates. The
// response channel gives packed words: a header of four command bytes, then
// the parameter words of that group. tuser marks the final word count that a
// finish command produces, and tlast marks the last word an input caused.
// The front is a four-stage pipeline that takes a word every cycle unless its
// last stage waits for room in the queue; it classifies the command, drops a
// repeated normal or texcoord and works out the exact squared error of both
// vertex forms. A four-entry queue holds its commands for the back, which
// takes one command at a time and sends the words through the single output
// register, one word a cycle while the receiver is ready. When the receiver
// stalls, the output register holds its word, the back waits, the queue fills
// and then req_tready falls.
// Reset empties the pipeline, the queue and the open group and clears the
// word count; a finish command does the same to the command state once its
// count word has been sent.
`timescale 1ns / 1ps
`default_nettype none

module gpu_display_list_packer (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [103:0] req_tdata,  // arg[4:0], coord_x, coord_y, coord_z, zero pad
   input  wire logic [2:0]   req_tuser,  // opcode
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [31:0]       rsp_tdata,  // word
   output logic              rsp_tuser,  // is_count
   output logic              rsp_tlast
);

   logic               q_push;
   logic               q_pop;
   logic               q_full;
   logic               q_valid;
   dlp_pkg::entry_type q_push_data;
   dlp_pkg::entry_type q_data;

   dlp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .opcode      (req_tuser),
      .arg         (req_tdata[4:0]),
      .coord_x     (req_tdata[36:5]),
      .coord_y     (req_tdata[68:37]),
      .coord_z     (req_tdata[100:69]),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   dlp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_full    (q_full)
   );

   dlp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_word     (rsp_tdata),
      .rsp_is_count (rsp_tuser),
      .rsp_last     (rsp_tlast)
   );

   // The front must never offer a command that the queue has no room for.
   assert property (@(posedge clock) disable iff (reset) q_push |-> !q_full)
      else $error("command pushed into a full queue");

   // A count word always closes the output of its finish command.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("count word without last");

   // The back only pops when the queue holds a command.
   assert property (@(posedge clock) disable iff (reset)
                    q_pop && !q_valid |=> 1'b0)
      else $error("pop from an empty queue");

endmodule

`default_nettype wire

// ----- sv/dlp_front.sv -----
// Front part: accepts commands, converts coordinates, drops repeats, picks vertex forms.
`timescale 1ns / 1ps
`default_nettype none

module dlp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [2:0]         opcode,
   input  wire logic [4:0]         arg,
   input  wire logic signed [31:0] coord_x,
   input  wire logic signed [31:0] coord_y,
   input  wire logic signed [31:0] coord_z,
   input  wire logic               q_full,
   output logic                    q_push,
   output dlp_pkg::entry_type      q_push_data
);

   logic               accept;
   logic               adv;
   logic signed [31:0] coord [3];

   logic signed [31:0] q8 [3];
   logic signed [31:0] q14 [3];
   logic signed [31:0] q11 [3];
   logic signed [31:0] q16 [2];
   logic [15:0]        enc16 [3];
   logic [9:0]         enc10 [3];
   logic [9:0]         nrm10 [3];
   logic [15:0]        tex16 [2];
   logic signed [8:0]  rem16 [3];
   logic signed [8:0]  m16 [3];
   logic signed [14:0] rem10 [3];
   logic signed [8:0]  n10 [3];

   // Classification and repeat-detection state.
   logic [15:0] last_vtx_ff [3];
   logic [31:0] last_nrm_ff [3];
   logic [31:0] last_tex_ff [2];
   logic [2:0]  flags_ff;
   logic [2:0]  flags_in;
   logic [2:0]  vtx_wr;
   logic        nrm_wr;
   logic        tex_wr;
   logic        keep;
   logic        full_vtx;
   logic [31:0] p10;
   dlp_pkg::entry_type ent;

   // Pipeline stage 1: classified command and error terms.
   logic               s1_valid_ff, s1_valid_in;
   dlp_pkg::entry_type s1_ent_ff;
   logic               s1_full_ff;
   logic [31:0]        s1_p10_ff;
   logic signed [8:0]  s1_rem16_ff [3];
   logic signed [8:0]  s1_m16_ff [3];
   logic signed [14:0] s1_rem10_ff [3];
   logic signed [8:0]  s1_n10_ff [3];

   // Stage 2: partial products of the squared errors.
   logic               s2_valid_ff;
   dlp_pkg::entry_type s2_ent_ff;
   logic               s2_full_ff;
   logic [31:0]        s2_p10_ff;
   logic signed [17:0] s2_a16_ff [3], s2_a16_in [3];
   logic signed [17:0] s2_b16_ff [3], s2_b16_in [3];
   logic signed [17:0] s2_c16_ff [3], s2_c16_in [3];
   logic signed [29:0] s2_a10_ff [3], s2_a10_in [3];
   logic signed [23:0] s2_b10_ff [3], s2_b10_in [3];
   logic signed [17:0] s2_c10_ff [3], s2_c10_in [3];

   // Stage 3: total squared error of each form.
   logic               s3_valid_ff;
   dlp_pkg::entry_type s3_ent_ff;
   logic               s3_full_ff;
   logic [31:0]        s3_p10_ff;
   dlp_pkg::err_type   s3_e16_ff, s3_e16_in;
   dlp_pkg::err_type   s3_e10_ff, s3_e10_in;

   // Stage 4: final command, waiting for room in the queue.
   logic               s4_valid_ff;
   dlp_pkg::entry_type s4_ent_ff, s4_ent_in;

   assign coord[0] = coord_x;
   assign coord[1] = coord_y;
   assign coord[2] = coord_z;

   assign adv        = !(s4_valid_ff && q_full);
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q8[i]    = dlp_pkg::trunc_shift(coord[i], 8);
         q14[i]   = dlp_pkg::trunc_shift(coord[i], 14);
         q11[i]   = dlp_pkg::trunc_shift(coord[i], 11);
         enc16[i] = q8[i][15:0];
         enc10[i] = q14[i][9:0];
         // The remainders are small, so the low bits of the difference are exact.
         rem16[i] = 9'(coord[i] - (q8[i] <<< 8));
         rem10[i] = 15'(coord[i] - (q14[i] <<< 14));
         // Whole multiples of 2^24 lost when the quotient wraps to its width.
         m16[i]   = {q8[i][23], q8[i][23:16]} + {8'd0, q8[i][15]};
         n10[i]   = {q14[i][17], q14[i][17:10]} + {8'd0, q14[i][9]};
         if (q11[i] < -32'sd512) begin
            nrm10[i] = dlp_pkg::NRM_MIN;
         end else if (q11[i] > 32'sd511) begin
            nrm10[i] = dlp_pkg::NRM_MAX;
         end else begin
            nrm10[i] = q11[i][9:0];
         end
      end
      for (int j = 0; j < 2; j++) begin
         q16[j]   = dlp_pkg::trunc_shift(coord[j], 16);
         tex16[j] = q16[j][15:0];
      end
   end

   always_comb begin
      ent      = '0;
      keep     = 1'b1;
      full_vtx = 1'b0;
      vtx_wr   = 3'b000;
      nrm_wr   = 1'b0;
      tex_wr   = 1'b0;
      flags_in = flags_ff;
      p10      = {2'b00, enc10[2], enc10[1], enc10[0]};
      unique case (dlp_pkg::opcode_type'(opcode))
         dlp_pkg::OP_NOP: begin
            ent.cmd = dlp_pkg::CMD_NOP;
         end
         dlp_pkg::OP_RESTORE: begin
            ent.cmd     = dlp_pkg::CMD_RESTORE;
            ent.nparams = 2'd1;
            ent.p0      = 32'(arg);
         end
         dlp_pkg::OP_BEGIN: begin
            ent.cmd     = dlp_pkg::CMD_BEGIN;
            ent.nparams = 2'd1;
            ent.p0      = 32'(arg);
         end
         dlp_pkg::OP_END: begin
            ent.cmd = dlp_pkg::CMD_END;
         end
         dlp_pkg::OP_NORMAL: begin
            if (flags_ff[dlp_pkg::FLAG_NRM] && last_nrm_ff[0] == coord[0] &&
                last_nrm_ff[1] == coord[1] && last_nrm_ff[2] == coord[2]) begin
               keep = 1'b0;
            end else begin
               ent.cmd     = dlp_pkg::CMD_NORMAL;
               ent.nparams = 2'd1;
               ent.p0      = {2'b00, nrm10[2], nrm10[1], nrm10[0]};
               nrm_wr      = 1'b1;
               flags_in[dlp_pkg::FLAG_NRM] = 1'b1;
            end
         end
         dlp_pkg::OP_TEXCOORD: begin
            if (flags_ff[dlp_pkg::FLAG_TEX] && last_tex_ff[0] == coord[0] &&
                last_tex_ff[1] == coord[1]) begin
               keep = 1'b0;
            end else begin
               ent.cmd     = dlp_pkg::CMD_TEXCOORD;
               ent.nparams = 2'd1;
               ent.p0      = {tex16[1], tex16[0]};
               tex_wr      = 1'b1;
               flags_in[dlp_pkg::FLAG_TEX] = 1'b1;
            end
         end
         dlp_pkg::OP_VERTEX: begin
            ent.nparams = 2'd1;
            if (flags_ff[dlp_pkg::FLAG_VTX] && last_vtx_ff[0] == enc16[0]) begin
               ent.cmd = dlp_pkg::CMD_VTX_YZ;
               ent.p0  = {enc16[2], enc16[1]};
               vtx_wr  = 3'b110;
            end else if (flags_ff[dlp_pkg::FLAG_VTX] && last_vtx_ff[1] == enc16[1]) begin
               ent.cmd = dlp_pkg::CMD_VTX_XZ;
               ent.p0  = {enc16[2], enc16[0]};
               vtx_wr  = 3'b101;
            end else if (flags_ff[dlp_pkg::FLAG_VTX] && last_vtx_ff[2] == enc16[2]) begin
               ent.cmd = dlp_pkg::CMD_VTX_XY;
               ent.p0  = {enc16[1], enc16[0]};
               vtx_wr  = 3'b011;
            end else begin
               // Full vertex: the 16-bit form for now, stage 4 may swap in the 10-bit one.
               full_vtx    = 1'b1;
               ent.cmd     = dlp_pkg::CMD_VTX16;
               ent.nparams = 2'd2;
               ent.p0      = {enc16[1], enc16[0]};
               ent.p1      = {16'd0, enc16[2]};
               vtx_wr      = 3'b111;
               flags_in[dlp_pkg::FLAG_VTX] = 1'b1;
            end
         end
         dlp_pkg::OP_FINISH: begin
            ent.is_finish = 1'b1;
            flags_in      = 3'b000;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= 3'b000;
      end else if (accept) begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            if (vtx_wr[i]) begin
               last_vtx_ff[i] <= enc16[i];
            end
            if (nrm_wr) begin
               last_nrm_ff[i] <= coord[i];
            end
         end
         if (tex_wr) begin
            last_tex_ff[0] <= coord[0];
            last_tex_ff[1] <= coord[1];
         end
      end
   end

   assign s1_valid_in = accept && keep;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_a16_in[i] = 18'(s1_rem16_ff[i]) * 18'(s1_rem16_ff[i]);
         s2_b16_in[i] = 18'(s1_rem16_ff[i]) * 18'(s1_m16_ff[i]);
         s2_c16_in[i] = 18'(s1_m16_ff[i]) * 18'(s1_m16_ff[i]);
         s2_a10_in[i] = 30'(s1_rem10_ff[i]) * 30'(s1_rem10_ff[i]);
         s2_b10_in[i] = 24'(s1_rem10_ff[i]) * 24'(s1_n10_ff[i]);
         s2_c10_in[i] = 18'(s1_n10_ff[i]) * 18'(s1_n10_ff[i]);
      end
   end

   // Error of one coordinate is rem + k * 2^24, so its square is
   // rem^2 + 2^25 * rem * k + 2^48 * k^2.
   always_comb begin
      s3_e16_in = '0;
      s3_e10_in = '0;
      for (int i = 0; i < 3; i++) begin
         s3_e16_in = s3_e16_in + dlp_pkg::err_type'(s2_a16_ff[i])
                   + (dlp_pkg::err_type'(s2_b16_ff[i]) <<< 25)
                   + (dlp_pkg::err_type'(s2_c16_ff[i]) <<< 48);
         s3_e10_in = s3_e10_in + dlp_pkg::err_type'(s2_a10_ff[i])
                   + (dlp_pkg::err_type'(s2_b10_ff[i]) <<< 25)
                   + (dlp_pkg::err_type'(s2_c10_ff[i]) <<< 48);
      end
   end

   always_comb begin
      s4_ent_in = s3_ent_ff;
      if (s3_full_ff && s3_e10_ff <= s3_e16_ff) begin
         s4_ent_in.cmd     = dlp_pkg::CMD_VTX10;
         s4_ent_in.nparams = 2'd1;
         s4_ent_in.p0      = s3_p10_ff;
         s4_ent_in.p1      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ent_ff  <= ent;
         s1_full_ff <= full_vtx;
         s1_p10_ff  <= p10;
         s2_ent_ff  <= s1_ent_ff;
         s2_full_ff <= s1_full_ff;
         s2_p10_ff  <= s1_p10_ff;
         s3_ent_ff  <= s2_ent_ff;
         s3_full_ff <= s2_full_ff;
         s3_p10_ff  <= s2_p10_ff;
         s3_e16_ff  <= s3_e16_in;
         s3_e10_ff  <= s3_e10_in;
         s4_ent_ff  <= s4_ent_in;
         for (int i = 0; i < 3; i++) begin
            s1_rem16_ff[i] <= rem16[i];
            s1_m16_ff[i]   <= m16[i];
            s1_rem10_ff[i] <= rem10[i];
            s1_n10_ff[i]   <= n10[i];
            s2_a16_ff[i]   <= s2_a16_in[i];
            s2_b16_ff[i]   <= s2_b16_in[i];
            s2_c16_ff[i]   <= s2_c16_in[i];
            s2_a10_ff[i]   <= s2_a10_in[i];
            s2_b10_ff[i]   <= s2_b10_in[i];
            s2_c10_ff[i]   <= s2_c10_in[i];
         end
      end
   end

   assign q_push      = s4_valid_ff && !q_full;
   assign q_push_data = s4_ent_ff;

endmodule

`default_nettype wire

// ----- sv/dlp_queue.sv -----
// Short command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module dlp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire dlp_pkg::entry_type  push_data,
   input  wire logic                pop,
   output logic                     q_valid,
   output dlp_pkg::entry_type       q_data,
   output logic                     q_full
);

   dlp_pkg::entry_type               slot_ff [dlp_pkg::QUEUE_DEPTH];
   logic [dlp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [dlp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [dlp_pkg::QCNT_W-1:0]       level_ff, level_in;
   logic                             do_push;
   logic                             do_pop;

   assign q_valid = level_ff != '0;
   assign q_full  = level_ff == dlp_pkg::QCNT_W'(dlp_pkg::QUEUE_DEPTH);
   assign q_data  = slot_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + dlp_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + dlp_pkg::QPTR_W'(1) : rd_ptr_ff;
      level_in  = level_ff;
      if (do_push && !do_pop) begin
         level_in = level_ff + dlp_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - dlp_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- sv/dlp_back.sv -----
// Back part: collects commands into groups and emits header, parameter and count words.
`timescale 1ns / 1ps
`default_nettype none

module dlp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  wire dlp_pkg::entry_type  q_data,
   output logic                     q_pop,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [31:0]              rsp_word,
   output logic                     rsp_is_count,
   output logic                     rsp_last
);

   dlp_pkg::back_state_type state_ff, state_in;

   logic [7:0]  cmds_ff [dlp_pkg::COMMANDS_PER_GROUP];
   logic [31:0] params_ff [dlp_pkg::MAX_PARAMS];

   logic [dlp_pkg::CMD_CNT_W-1:0]   cmd_cnt_ff, cmd_cnt_in;
   logic [dlp_pkg::PAR_CNT_W-1:0]   par_cnt_ff, par_cnt_in;
   logic [dlp_pkg::PAR_CNT_W-1:0]   idx_ff, idx_in;
   logic                            finish_ff, finish_in;
   logic [dlp_pkg::COUNT_WIDTH-1:0] words_ff, words_in, words_inc;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_word_ff, out_word_in;
   logic        out_count_ff, out_count_in;
   logic        out_last_ff, out_last_in;

   logic                          load_ok;
   logic                          cmd_we;
   logic                          par_we0;
   logic                          par_we1;
   logic [dlp_pkg::CMD_IDX_W-1:0] cmd_wr_idx;
   logic [dlp_pkg::PAR_IDX_W-1:0] par_wr_idx0;
   logic [dlp_pkg::PAR_IDX_W-1:0] par_wr_idx1;
   logic [dlp_pkg::PAR_IDX_W-1:0] par_rd_idx;
   logic [31:0]                   header;

   assign load_ok     = !out_valid_ff || rsp_tready;
   assign cmd_wr_idx  = dlp_pkg::CMD_IDX_W'(cmd_cnt_ff);
   assign par_wr_idx0 = dlp_pkg::PAR_IDX_W'(par_cnt_ff);
   assign par_wr_idx1 = dlp_pkg::PAR_IDX_W'(par_cnt_ff + dlp_pkg::PAR_CNT_W'(1));
   assign par_rd_idx  = dlp_pkg::PAR_IDX_W'(idx_ff - dlp_pkg::PAR_CNT_W'(1));
   assign words_inc   = (words_ff == '1) ? words_ff
                                         : words_ff + dlp_pkg::COUNT_WIDTH'(1);

   // Slots past the fill count are nops, which pads a group cut short by finish.
   always_comb begin
      for (int i = 0; i < dlp_pkg::COMMANDS_PER_GROUP; i++) begin
         header[8*i +: 8] = (dlp_pkg::CMD_CNT_W'(i) < cmd_cnt_ff) ? cmds_ff[i]
                                                                  : dlp_pkg::CMD_NOP;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_cnt_in   = cmd_cnt_ff;
      par_cnt_in   = par_cnt_ff;
      idx_in       = idx_ff;
      finish_in    = finish_ff;
      words_in     = words_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_word_in  = out_word_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      cmd_we       = 1'b0;
      par_we0      = 1'b0;
      par_we1      = 1'b0;
      unique case (state_ff)
         dlp_pkg::BK_RUN: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_data.is_finish) begin
                  finish_in = 1'b1;
                  idx_in    = '0;
                  state_in  = (cmd_cnt_ff == '0) ? dlp_pkg::BK_COUNT : dlp_pkg::BK_FLUSH;
               end else begin
                  cmd_we     = 1'b1;
                  par_we0    = q_data.nparams != 2'd0;
                  par_we1    = q_data.nparams == 2'd2;
                  cmd_cnt_in = cmd_cnt_ff + dlp_pkg::CMD_CNT_W'(1);
                  par_cnt_in = par_cnt_ff + dlp_pkg::PAR_CNT_W'(q_data.nparams);
                  if (cmd_cnt_ff == dlp_pkg::CMD_CNT_W'(dlp_pkg::COMMANDS_PER_GROUP - 1)) begin
                     finish_in = 1'b0;
                     idx_in    = '0;
                     state_in  = dlp_pkg::BK_FLUSH;
                  end
               end
            end
         end
         dlp_pkg::BK_FLUSH: begin
            if (load_ok) begin
               out_valid_in = 1'b1;
               out_count_in = 1'b0;
               out_word_in  = (idx_ff == '0) ? header : params_ff[par_rd_idx];
               out_last_in  = (idx_ff == par_cnt_ff) && !finish_ff;
               words_in     = words_inc;
               idx_in       = idx_ff + dlp_pkg::PAR_CNT_W'(1);
               if (idx_ff == par_cnt_ff) begin
                  cmd_cnt_in = '0;
                  par_cnt_in = '0;
                  state_in   = finish_ff ? dlp_pkg::BK_COUNT : dlp_pkg::BK_RUN;
               end
            end
         end
         dlp_pkg::BK_COUNT: begin
            if (load_ok) begin
               out_valid_in = 1'b1;
               out_count_in = 1'b1;
               out_last_in  = 1'b1;
               out_word_in  = 32'(words_ff);
               words_in     = '0;
               finish_in    = 1'b0;
               state_in     = dlp_pkg::BK_RUN;
            end
         end
         default: begin
            state_in = dlp_pkg::BK_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dlp_pkg::BK_RUN;
         cmd_cnt_ff   <= '0;
         par_cnt_ff   <= '0;
         idx_ff       <= '0;
         finish_ff    <= 1'b0;
         words_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_cnt_ff   <= cmd_cnt_in;
         par_cnt_ff   <= par_cnt_in;
         idx_ff       <= idx_in;
         finish_ff    <= finish_in;
         words_ff     <= words_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
      if (cmd_we) begin
         cmds_ff[cmd_wr_idx] <= q_data.cmd;
      end
      if (par_we0) begin
         params_ff[par_wr_idx0] <= q_data.p0;
      end
      if (par_we1) begin
         params_ff[par_wr_idx1] <= q_data.p1;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_word     = out_word_ff;
   assign rsp_is_count = out_count_ff;
   assign rsp_last     = out_last_ff;

endmodule

`default_nettype wire

// ----- verif/display_list_checker.sv -----
// Checker for the display list packer: predicts the packed words and compares them.
`timescale 1ns / 1ps

module display_list_checker
   import dlp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [103:0] req_tdata,  // arg[4:0], coord_x, coord_y, coord_z, zero pad
   input  wire logic [2:0]   req_tuser,  // opcode
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [31:0]  rsp_tdata,  // word
   input  wire logic         rsp_tuser,  // is_count
   input  wire logic         rsp_tlast,
   output int                fail_count,
   output int                pending
);

   typedef struct packed {
      logic [31:0] word;
      logic        is_count;
      logic        last;
   } packed_word_type;

   packed_word_type expected_words[$];
   packed_word_type want;
   int              errors = 0;
   int              words_seen = 0;

   // Own copy of the packer state.
   logic [7:0]  group_cmds[4];
   int          cmd_count;
   logic [31:0] group_params[8];
   int          param_count;
   logic [31:0] prev_vtx[3];
   logic [31:0] prev_nrm[3];
   logic [31:0] prev_uv[2];
   logic        have_vtx, have_nrm, have_uv;
   logic [31:0] word_total;

   function automatic longint quot_toward_zero(input logic [31:0] raw, input int shift);
      longint v;
      v = longint'(signed'(raw));
      if (v < 0) return -((-v) >> shift);
      return v >> shift;
   endfunction

   function automatic logic [15:0] vtx16(input logic [31:0] raw);
      longint q;
      q = quot_toward_zero(raw, 8);
      return q[15:0];
   endfunction

   function automatic logic [9:0] vtx10(input logic [31:0] raw);
      longint q;
      q = quot_toward_zero(raw, 14);
      return q[9:0];
   endfunction

   function automatic logic [15:0] uv16(input logic [31:0] raw);
      longint q;
      q = quot_toward_zero(raw, 16);
      return q[15:0];
   endfunction

   function automatic logic [9:0] nrm10(input logic [31:0] raw);
      longint q;
      q = quot_toward_zero(raw, 11);
      if (q < -512) q = -512;
      if (q > 511) q = 511;
      return q[9:0];
   endfunction

   // Squared distance between a raw coordinate and its coded value, in 2^-40 units.
   function automatic logic [79:0] trunc_error_sq(input logic [31:0] raw, input longint approx);
      longint      d;
      logic [79:0] m;
      d = longint'(signed'(raw)) - approx;
      if (d < 0) d = -d;
      m = 80'(d);
      return m * m;
   endfunction

   task automatic clear_packer_state();
      cmd_count   = 0;
      param_count = 0;
      prev_vtx    = '{32'h0, 32'h0, 32'h0};
      prev_nrm    = '{32'h0, 32'h0, 32'h0};
      prev_uv     = '{32'h0, 32'h0};
      have_vtx    = 1'b0;
      have_nrm    = 1'b0;
      have_uv     = 1'b0;
      word_total  = 32'h0;
   endtask

   task automatic put_word(input logic [31:0] w, input logic is_count);
      expected_words.insert(expected_words.size(), packed_word_type'{w, is_count, 1'b0});
      if (!is_count && word_total != 32'hFFFF_FFFF) word_total++;
   endtask

   task automatic add_command(input logic [7:0] cmd, input int nparams,
                              input logic [31:0] p0, input logic [31:0] p1);
      group_cmds[cmd_count % 4] = cmd;
      cmd_count++;
      if (nparams > 0 && param_count < 8) begin
         group_params[param_count] = p0;
         param_count++;
      end
      if (nparams > 1 && param_count < 8) begin
         group_params[param_count] = p1;
         param_count++;
      end
      if (cmd_count >= COMMANDS_PER_GROUP) begin
         put_word({group_cmds[3], group_cmds[2], group_cmds[1], group_cmds[0]}, 1'b0);
         for (int i = 0; i < param_count; i++) put_word(group_params[i], 1'b0);
         cmd_count   = 0;
         param_count = 0;
      end
   endtask

   task automatic encode_command(input opcode_type op, input logic [4:0] arg,
                                 input logic [31:0] x, input logic [31:0] y,
                                 input logic [31:0] z);
      int              item_start;
      packed_word_type tail;
      logic [81:0]     err16, err10;
      item_start = expected_words.size();
      case (op)
         OP_NOP:     add_command(CMD_NOP, 0, '0, '0);
         OP_RESTORE: add_command(CMD_RESTORE, 1, {27'h0, arg}, '0);
         OP_BEGIN:   add_command(CMD_BEGIN, 1, {27'h0, arg}, '0);
         OP_END:     add_command(CMD_END, 0, '0, '0);
         OP_NORMAL: begin
            // A normal equal to the last one sent adds nothing.
            if (!(have_nrm && prev_nrm[0] == x && prev_nrm[1] == y && prev_nrm[2] == z)) begin
               add_command(CMD_NORMAL, 1, {2'b00, nrm10(z), nrm10(y), nrm10(x)}, '0);
               prev_nrm = '{x, y, z};
               have_nrm = 1'b1;
            end
         end
         OP_TEXCOORD: begin
            if (!(have_uv && prev_uv[0] == x && prev_uv[1] == y)) begin
               add_command(CMD_TEXCOORD, 1, {uv16(y), uv16(x)}, '0);
               prev_uv = '{x, y};
               have_uv = 1'b1;
            end
         end
         OP_VERTEX: begin
            if (have_vtx && vtx16(prev_vtx[0]) == vtx16(x)) begin
               add_command(CMD_VTX_YZ, 1, {vtx16(z), vtx16(y)}, '0);
               prev_vtx[1] = y;
               prev_vtx[2] = z;
            end else if (have_vtx && vtx16(prev_vtx[1]) == vtx16(y)) begin
               add_command(CMD_VTX_XZ, 1, {vtx16(z), vtx16(x)}, '0);
               prev_vtx[0] = x;
               prev_vtx[2] = z;
            end else if (have_vtx && vtx16(prev_vtx[2]) == vtx16(z)) begin
               add_command(CMD_VTX_XY, 1, {vtx16(y), vtx16(x)}, '0);
               prev_vtx[0] = x;
               prev_vtx[1] = y;
            end else begin
               err16 = trunc_error_sq(x, longint'(signed'(vtx16(x))) * 256)
                     + trunc_error_sq(y, longint'(signed'(vtx16(y))) * 256)
                     + trunc_error_sq(z, longint'(signed'(vtx16(z))) * 256);
               err10 = trunc_error_sq(x, longint'(signed'(vtx10(x))) * 16384)
                     + trunc_error_sq(y, longint'(signed'(vtx10(y))) * 16384)
                     + trunc_error_sq(z, longint'(signed'(vtx10(z))) * 16384);
               // A tie goes to the shorter form.
               if (err10 <= err16)
                  add_command(CMD_VTX10, 1, {2'b00, vtx10(z), vtx10(y), vtx10(x)}, '0);
               else
                  add_command(CMD_VTX16, 2, {vtx16(y), vtx16(x)}, {16'h0, vtx16(z)});
               prev_vtx = '{x, y, z};
               have_vtx = 1'b1;
            end
         end
         default: begin
            while (cmd_count != 0) add_command(CMD_NOP, 0, '0, '0);
            put_word(word_total, 1'b1);
            clear_packer_state();
         end
      endcase
      if (expected_words.size() > item_start) begin
         tail = expected_words[expected_words.size() - 1];
         tail.last = 1'b1;
         expected_words[expected_words.size() - 1] = tail;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_packer_state();
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("word %0d: none expected, got %h is_count %b last %b",
                           words_seen, rsp_tdata, rsp_tuser, rsp_tlast);
            end else begin
               want = expected_words.pop_front();
               if (want != {rsp_tdata, rsp_tuser, rsp_tlast}) begin
                  errors++;
                  if (errors <= 10)
                     $display("word %0d: expected %h is_count %b last %b, got %h is_count %b last %b",
                              words_seen, want.word, want.is_count, want.last,
                              rsp_tdata, rsp_tuser, rsp_tlast);
               end
            end
            words_seen++;
         end
         if (req_tvalid && req_tready)
            encode_command(opcode_type'(req_tuser), req_tdata[4:0], req_tdata[36:5],
                           req_tdata[68:37], req_tdata[100:69]);
      end
      fail_count <= errors;
      pending    <= expected_words.size();
   end

endmodule

// ----- verif/testbench.sv -----
// Top of the display list packer testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import dlp_pkg::*;

   localparam int RANDOM_ITEMS = 320;
   localparam int IDLE_LIMIT   = 2000;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata  = '0;
   logic [2:0]   req_tuser  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   int           fail_count;
   int           pending;

   int           items_sent  = 0;
   int           burst_left  = 0;
   int           idle_cycles = 0;
   int           ready_mode  = 0;
   int           mode_left   = 0;
   logic [31:0]  sent_vtx[3] = '{32'h0, 32'h0, 32'h0};
   logic [31:0]  sent_nrm[3] = '{32'h0, 32'h0, 32'h0};
   logic [31:0]  sent_uv[2]  = '{32'h0, 32'h0};

   gpu_display_list_packer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   display_list_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver switches at random among four stall behaviours, from always ready to mostly stalled.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 120);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ($urandom_range(0, 1) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("gpu_display_list_packer: mismatch");
         $finish;
      end
   end

   function automatic logic [31:0] random_coord();
      logic [31:0] small_val;
      small_val = $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return small_val & 32'hFFFF_C000;
         2: return small_val & 32'hFFFF_FF00;
         3: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0000_0000;
            endcase
         end
         default: return small_val;
      endcase
   endfunction

   // Presents one command word, waits for it to be taken, then maybe opens a gap.
   task automatic send_item(input opcode_type op, input logic [4:0] arg,
                            input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
      req_tuser  <= op;
      req_tdata  <= {3'b000, z, y, x, arg};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      case (op)
         OP_VERTEX:   sent_vtx = '{x, y, z};
         OP_NORMAL:   sent_nrm = '{x, y, z};
         OP_TEXCOORD: sent_uv  = '{x, y};
         default: ;
      endcase
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 10);
      end
   endtask

   task automatic send_vertex();
      logic [31:0] x, y, z;
      x = random_coord();
      y = random_coord();
      z = random_coord();
      // Reusing a coordinate of the last vertex steers into the two-coordinate forms.
      case ($urandom_range(0, 5))
         0:       x = sent_vtx[0];
         1:       y = sent_vtx[1];
         2:       z = sent_vtx[2];
         default: ;
      endcase
      send_item(OP_VERTEX, 5'd0, x, y, z);
   endtask

   initial begin
      int  choice;
      int  nverts;
      bit  paused;
      paused = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      send_item(OP_NOP,      5'd0,  32'h0, 32'h0, 32'h0);
      send_item(OP_RESTORE,  5'd31, 32'h0, 32'h0, 32'h0);
      send_item(OP_BEGIN,    5'd0,  32'h0, 32'h0, 32'h0);
      send_item(OP_END,      5'd0,  32'h0, 32'h0, 32'h0);
      send_item(OP_NORMAL,   5'd0,  32'h7FFF_FFFF, 32'h8000_0000, 32'h000F_FFFF);
      send_item(OP_NORMAL,   5'd0,  32'h7FFF_FFFF, 32'h8000_0000, 32'h000F_FFFF);
      send_item(OP_TEXCOORD, 5'd0,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_item(OP_TEXCOORD, 5'd0,  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
      send_item(OP_VERTEX,   5'd0,  32'h0010_0123, 32'hFFF0_0457, 32'h0000_0001);
      send_item(OP_VERTEX,   5'd0,  32'h0020_4000, 32'h0020_8000, 32'hFFFF_C000);
      send_item(OP_VERTEX,   5'd0,  32'h0020_4000, 32'h0030_0000, 32'h0040_0000);
      send_item(OP_VERTEX,   5'd0,  32'h0050_0000, 32'h0030_0000, 32'h0060_0000);
      send_item(OP_VERTEX,   5'd0,  32'h0070_0000, 32'h0080_0000, 32'h0060_0000);
      send_item(OP_FINISH,   5'd0,  32'h0, 32'h0, 32'h0);
      send_item(OP_FINISH,   5'd0,  32'h0, 32'h0, 32'h0);
      send_item(OP_RESTORE,  5'd0,  32'h0, 32'h0, 32'h0);
      send_item(OP_BEGIN,    5'd31, 32'h0, 32'h0, 32'h0);
      send_item(OP_VERTEX,   5'd0,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
      // After a finish the last-sent values are forgotten, so zero values are sent.
      send_item(OP_TEXCOORD, 5'd0,  32'h0, 32'h0, 32'h0);
      send_item(OP_NORMAL,   5'd0,  32'h0, 32'h0, 32'h0);
      send_item(OP_FINISH,   5'd0,  32'h0, 32'h0, 32'h0);

      // Random part: mostly primitives, with loose commands and noise among them.
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 99);
         if (choice < 60) begin
            send_item(OP_BEGIN, 5'($urandom_range(0, 31)), 32'h0, 32'h0, 32'h0);
            nverts = $urandom_range(1, 8);
            repeat (nverts) begin
               if ($urandom_range(0, 2) == 0) begin
                  if ($urandom_range(0, 2) == 0)
                     send_item(OP_NORMAL, 5'd0, sent_nrm[0], sent_nrm[1], sent_nrm[2]);
                  else
                     send_item(OP_NORMAL, 5'd0, random_coord(), random_coord(),
                               random_coord());
               end
               if ($urandom_range(0, 2) == 0) begin
                  if ($urandom_range(0, 2) == 0)
                     send_item(OP_TEXCOORD, 5'd0, sent_uv[0], sent_uv[1], $urandom());
                  else
                     send_item(OP_TEXCOORD, 5'd0, random_coord(), random_coord(),
                               $urandom());
               end
               send_vertex();
            end
            if ($urandom_range(0, 9) != 0)
               send_item(OP_END, 5'($urandom_range(0, 31)), $urandom(), $urandom(), $urandom());
         end else if (choice < 75) begin
            send_item(opcode_type'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                      $urandom(), $urandom(), $urandom());
         end else if (choice < 85) begin
            send_item(OP_RESTORE, 5'($urandom_range(0, 31)), $urandom(), $urandom(), $urandom());
         end else if (choice < 94) begin
            send_item(OP_NOP, 5'($urandom_range(0, 31)), $urandom(), $urandom(), $urandom());
         end else begin
            send_item(OP_FINISH, 5'($urandom_range(0, 31)), $urandom(), $urandom(), $urandom());
         end
         if (!paused && items_sent >= RANDOM_ITEMS / 2) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("gpu_display_list_packer: match");
      else
         $display("gpu_display_list_packer: mismatch");
      $finish;
   end

endmodule
